FILE: design/tvnf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvnf_pkg
// Shared types and byte constants for the text visualise/number filter.
// ----------------------------------------------------------------------------
package tvnf_pkg;

    // Kind of line prefix carried with an item
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_NUM,
        PFX_BLANK
    } pfx_t;

    // Classified item handed from the front end to the output serialiser
    typedef struct packed {
        pfx_t            pfx;        // line prefix kind
        logic [1:0]      body_last;  // index of the final body byte
        logic [3:0][7:0] body;       // body bytes, element 0 sent first
    } desc_ctl_t;

    // Byte codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UPPERI = 8'h49;
    localparam logic [7:0] CH_UPPERM = 8'h4D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [6:0] CH_DEL    = 7'h7F;
    localparam logic [6:0] CTRL_LIMIT = 7'h20;
    localparam logic [6:0] CTRL_SHOW = 7'h40;
    localparam logic [3:0] DIGIT_NINE = 4'd9;

endpackage
`default_nettype wire

FILE: design/tvnf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvnf_front
// Input stage: takes one byte per cycle while accept is high, tracks line
// start, squeeze state and the decimal line counter, and classifies the byte
// into a prefix kind and up to four body bytes.
// ----------------------------------------------------------------------------
module tvnf_front #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // configuration
    input  wire                              squeeze_blank,
    input  wire                              number_lines,
    input  wire                              number_nonblank_only,
    input  wire                              show_ends,
    input  wire                              show_tabs,
    input  wire                              show_nonprint,
    // incoming item
    input  wire                              accept,
    input  wire  [7:0]                       in_byte,
    input  wire                              file_start,
    // classified item towards the queue
    output logic                             push,
    output tvnf_pkg::desc_ctl_t              push_ctl,
    output logic [NUMBER_DIGITS-1:0][3:0]    push_digits
);
    import tvnf_pkg::*;

    logic                           at_line_start_reg, at_line_start_next;
    logic                           squeezing_reg, squeezing_next;
    logic [NUMBER_DIGITS-1:0][3:0]  digits_reg, digits_next;

    logic                           ls_eff, sq_eff;
    logic [NUMBER_DIGITS-1:0][3:0]  dig_eff, dig_inc;
    logic                           all_nine, carry;
    logic                           is_nl, is_tab, drop, do_number;
    logic [6:0]                     low7;
    logic                           is_ctrl;
    logic [7:0]                     ctrl_char;

    // file start clears the state before the byte is handled
    assign ls_eff  = file_start | at_line_start_reg;
    assign sq_eff  = ~file_start & squeezing_reg;
    assign dig_eff = file_start ? '0 : digits_reg;

    assign is_nl  = (in_byte == CH_NL);
    assign is_tab = (in_byte == CH_TAB);
    assign drop   = ls_eff & squeeze_blank & is_nl & sq_eff;
    assign do_number = ls_eff & number_lines & (~number_nonblank_only | ~is_nl);

    // saturating decimal increment, digit 0 least significant
    always_comb
    begin
        all_nine = 1'b1;
        carry    = 1'b1;
        dig_inc  = dig_eff;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (dig_eff[i] != DIGIT_NINE)
                all_nine = 1'b0;
        end
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            if (carry)
            begin
                if (dig_eff[i] == DIGIT_NINE)
                    dig_inc[i] = '0;
                else
                begin
                    dig_inc[i] = dig_eff[i] + 4'd1;
                    carry      = 1'b0;
                end
            end
        end
        if (all_nine)
            dig_inc = dig_eff;
    end

    // next line state; a squeezed newline leaves the counter alone
    always_comb
    begin
        at_line_start_next = is_nl;
        squeezing_next     = sq_eff;
        if (ls_eff && squeeze_blank)
            squeezing_next = is_nl;
        digits_next = (do_number && !drop) ? dig_inc : dig_eff;
    end

    assign low7      = in_byte[6:0];
    assign is_ctrl   = (low7 < CTRL_LIMIT) || (low7 == CH_DEL);
    assign ctrl_char = (low7 == CH_DEL) ? CH_QMARK : {1'b0, low7 | CTRL_SHOW};

    // classify the byte
    always_comb
    begin
        push_ctl.body      = '0;
        push_ctl.body_last = 2'd0;
        if (do_number)
            push_ctl.pfx = PFX_NUM;
        else if (ls_eff && number_lines && show_ends)
            push_ctl.pfx = PFX_BLANK;
        else
            push_ctl.pfx = PFX_NONE;

        if (is_nl)
        begin
            if (show_ends)
            begin
                push_ctl.body[0]   = CH_DOLLAR;
                push_ctl.body[1]   = CH_NL;
                push_ctl.body_last = 2'd1;
            end
            else
                push_ctl.body[0] = CH_NL;
        end
        else if (is_tab)
        begin
            if (show_tabs)
            begin
                push_ctl.body[0]   = CH_CARET;
                push_ctl.body[1]   = CH_UPPERI;
                push_ctl.body_last = 2'd1;
            end
            else
                push_ctl.body[0] = CH_TAB;
        end
        else if (show_nonprint)
        begin
            if (in_byte[7])
            begin
                push_ctl.body[0] = CH_UPPERM;
                push_ctl.body[1] = CH_DASH;
                if (is_ctrl)
                begin
                    push_ctl.body[2]   = CH_CARET;
                    push_ctl.body[3]   = ctrl_char;
                    push_ctl.body_last = 2'd3;
                end
                else
                begin
                    push_ctl.body[2]   = {1'b0, low7};
                    push_ctl.body_last = 2'd2;
                end
            end
            else if (is_ctrl)
            begin
                push_ctl.body[0]   = CH_CARET;
                push_ctl.body[1]   = ctrl_char;
                push_ctl.body_last = 2'd1;
            end
            else
                push_ctl.body[0] = in_byte;
        end
        else
            push_ctl.body[0] = in_byte;
    end

    assign push        = accept & ~drop;
    assign push_digits = dig_inc;

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            squeezing_reg     <= 1'b0;
            digits_reg        <= '0;
        end
        else if (accept)
        begin
            at_line_start_reg <= at_line_start_next;
            squeezing_reg     <= squeezing_next;
            digits_reg        <= digits_next;
        end
    end

endmodule
`default_nettype wire

FILE: design/tvnf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvnf_queue
// Two-entry queue of classified items between the front end and the output
// serialiser.
// ----------------------------------------------------------------------------
module tvnf_queue #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              push,
    input  tvnf_pkg::desc_ctl_t              push_ctl,
    input  wire  [NUMBER_DIGITS-1:0][3:0]    push_digits,
    input  wire                              pop,
    output logic                             full,
    output logic                             not_empty,
    output tvnf_pkg::desc_ctl_t              head_ctl,
    output logic [NUMBER_DIGITS-1:0][3:0]    head_digits
);
    import tvnf_pkg::*;

    desc_ctl_t                      ctl_mem [2];
    logic [NUMBER_DIGITS-1:0][3:0]  dig_mem [2];
    logic                           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                     count_reg;

    assign full        = (count_reg == 2'd2);
    assign not_empty   = (count_reg != 2'd0);
    assign head_ctl    = ctl_mem[rd_ptr_reg];
    assign head_digits = dig_mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg] <= push_ctl;
            dig_mem[wr_ptr_reg] <= push_digits;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule
`default_nettype wire

FILE: design/tvnf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tvnf_back
// Output serialiser: walks one queued item byte by byte (number or blank
// prefix, tab, then body) into a registered output stage.
// ----------------------------------------------------------------------------
module tvnf_back #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              q_not_empty,
    input  tvnf_pkg::desc_ctl_t              q_ctl,
    input  wire  [NUMBER_DIGITS-1:0][3:0]    q_digits,
    output logic                             pop,
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [7:0]                       out_byte,
    output logic                             last_of_run
);
    import tvnf_pkg::*;

    localparam int PW  = $clog2(NUMBER_DIGITS + 5);
    localparam int DIW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
    localparam logic [PW-1:0] TAB_POS  = PW'(NUMBER_DIGITS);
    localparam logic [PW-1:0] BODY_POS = PW'(NUMBER_DIGITS + 1);
    localparam logic [PW-1:0] LSD_POS  = PW'(NUMBER_DIGITS - 1);

    logic                           cur_valid_reg;
    desc_ctl_t                      cur_ctl_reg;
    logic [NUMBER_DIGITS-1:0][3:0]  cur_dig_reg;
    logic [PW-1:0]                  pos_reg;
    logic                           lead_reg;
    logic                           out_valid_reg;
    logic [7:0]                     out_byte_reg;
    logic                           last_reg;

    logic                           byte_go, cur_last;
    logic [PW-1:0]                  dig_sel, body_sel;
    logic [3:0]                     dig;
    logic [7:0]                     byte_next;

    assign byte_go  = cur_valid_reg & (~out_valid_reg | ~out_stall);
    assign body_sel = pos_reg - BODY_POS;
    assign cur_last = (pos_reg == BODY_POS + PW'(cur_ctl_reg.body_last));
    assign pop      = q_not_empty & (~cur_valid_reg | (byte_go & cur_last));

    // digit under the cursor, most significant first
    assign dig_sel = LSD_POS - pos_reg;
    assign dig     = cur_dig_reg[dig_sel[DIW-1:0]];

    // byte at the current position
    always_comb
    begin
        if (pos_reg < TAB_POS)
        begin
            if (cur_ctl_reg.pfx == PFX_NUM && !(lead_reg && dig == 4'd0 && pos_reg != LSD_POS))
                byte_next = CH_ZERO + {4'd0, dig};
            else
                byte_next = CH_SPACE;
        end
        else if (pos_reg == TAB_POS)
            byte_next = CH_TAB;
        else
            byte_next = cur_ctl_reg.body[body_sel[1:0]];
    end

    // cursor over the current item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            lead_reg      <= 1'b1;
        end
        else if (pop)
        begin
            cur_valid_reg <= 1'b1;
            pos_reg       <= (q_ctl.pfx == PFX_NONE) ? BODY_POS : '0;
            lead_reg      <= 1'b1;
        end
        else if (byte_go)
        begin
            if (cur_last)
                cur_valid_reg <= 1'b0;
            pos_reg  <= pos_reg + PW'(1);
            lead_reg <= lead_reg & (dig == 4'd0);
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_ctl_reg <= q_ctl;
            cur_dig_reg <= q_digits;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (byte_go)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (byte_go)
        begin
            out_byte_reg <= byte_next;
            last_reg     <= cur_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

endmodule
`default_nettype wire

FILE: design/text_visualize_number_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_visualize_number_filter
// Byte-stream text filter: squeezes blank lines, numbers lines, and shows
// line ends, tabs and nonprinting bytes in visible notation.
// ----------------------------------------------------------------------------
// One input byte is taken per clock while the two-entry item queue has room;
// the serialiser sends the bytes of an item in turn, so an input byte that
// expands to n output bytes (n is 1 to NUMBER_DIGITS + 5) holds it for all
// of them; a squeezed empty line is taken with no output. Plain text flows at
// one byte per cycle while the output is not stalled. With the filter idle,
// an item's first output byte goes from the queue to the serialiser's item
// register and then to its output register, from which it is presented.
// Registers sit at byte addresses 0, 4, ... 20 of the APB port (bit 0 counts);
// the user must write them only while the filter is idle (not enforced).
// ----------------------------------------------------------------------------
module text_visualize_number_filter #(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire         clk,
    input  wire         rst_n,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [7:0]  in_byte,
    input  wire         file_start,
    // output channel
    output logic        out_valid,
    input  wire         out_stall,
    output logic [7:0]  out_byte,
    output logic        last_of_run
);
    import tvnf_pkg::*;

    localparam logic [2:0] REG_SQUEEZE  = 3'd0;
    localparam logic [2:0] REG_NUMBER   = 3'd1;
    localparam logic [2:0] REG_NONBLANK = 3'd2;
    localparam logic [2:0] REG_ENDS     = 3'd3;
    localparam logic [2:0] REG_TABS     = 3'd4;
    localparam logic [2:0] REG_NONPRINT = 3'd5;

    logic squeeze_blank_reg, number_lines_reg, number_nonblank_only_reg;
    logic show_ends_reg, show_tabs_reg, show_nonprint_reg;
    logic cfg_write;
    logic [2:0] reg_idx;
    logic rd_bit;

    logic                           accept, push, q_full, q_not_empty, pop;
    desc_ctl_t                      push_ctl, head_ctl;
    logic [NUMBER_DIGITS-1:0][3:0]  push_digits, head_digits;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            squeeze_blank_reg        <= 1'b0;
            number_lines_reg         <= 1'b0;
            number_nonblank_only_reg <= 1'b0;
            show_ends_reg            <= 1'b0;
            show_tabs_reg            <= 1'b0;
            show_nonprint_reg        <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SQUEEZE:  squeeze_blank_reg        <= pwdata[0];
                REG_NUMBER:   number_lines_reg         <= pwdata[0];
                REG_NONBLANK: number_nonblank_only_reg <= pwdata[0];
                REG_ENDS:     show_ends_reg            <= pwdata[0];
                REG_TABS:     show_tabs_reg            <= pwdata[0];
                REG_NONPRINT: show_nonprint_reg        <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (reg_idx)
            REG_SQUEEZE:  rd_bit = squeeze_blank_reg;
            REG_NUMBER:   rd_bit = number_lines_reg;
            REG_NONBLANK: rd_bit = number_nonblank_only_reg;
            REG_ENDS:     rd_bit = show_ends_reg;
            REG_TABS:     rd_bit = show_tabs_reg;
            REG_NONPRINT: rd_bit = show_nonprint_reg;
            default:      rd_bit = 1'b0;
        endcase
    end
    assign prdata = {31'd0, rd_bit};

    // input transfer
    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    tvnf_front #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .squeeze_blank        (squeeze_blank_reg),
        .number_lines         (number_lines_reg),
        .number_nonblank_only (number_nonblank_only_reg),
        .show_ends            (show_ends_reg),
        .show_tabs            (show_tabs_reg),
        .show_nonprint        (show_nonprint_reg),
        .accept               (accept),
        .in_byte              (in_byte),
        .file_start           (file_start),
        .push                 (push),
        .push_ctl             (push_ctl),
        .push_digits          (push_digits)
    );

    tvnf_queue #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_digits (push_digits),
        .pop         (pop),
        .full        (q_full),
        .not_empty   (q_not_empty),
        .head_ctl    (head_ctl),
        .head_digits (head_digits)
    );

    tvnf_back #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_ctl       (head_ctl),
        .q_digits    (head_digits),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule
`default_nettype wire

FILE: tb/tvnf_stream_checker.sv
// ----------------------------------------------------------------------------
// tvnf_stream_checker
// Watches the register port and both byte channels of the text filter. It
// keeps its own copy of the registers and the line state, works out the bytes
// each accepted input should yield, and compares every output transfer in
// order. Register reads are checked against the shadow copy.
// ----------------------------------------------------------------------------
module tvnf_stream_checker
    import tvnf_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
) (
    input  wire         clk,
    input  wire         rst_n,
    // register port, observed only
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire  [31:0] prdata,
    input  wire         pready,
    // input channel
    input  wire         in_valid,
    input  wire         in_stall,
    input  wire  [7:0]  in_byte,
    input  wire         file_start,
    // output channel
    input  wire         out_valid,
    input  wire         out_stall,
    input  wire  [7:0]  out_byte,
    input  wire         last_of_run,
    // status for the test top
    output int          failures,
    output int          pending
);

    // Register indexes
    localparam int REG_SQUEEZE_BLANK  = 0;
    localparam int REG_NUMBER_LINES   = 1;
    localparam int REG_NONBLANK_ONLY  = 2;
    localparam int REG_SHOW_ENDS      = 3;
    localparam int REG_SHOW_TABS      = 4;
    localparam int REG_SHOW_NONPRINT  = 5;
    localparam int REG_COUNT          = 6;

    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } out_beat_t;

    out_beat_t  expected_text [$];
    logic [5:0] reg_bits;
    logic       line_start;
    logic       blank_kept;
    logic [3:0] line_count [NUMBER_DIGITS];   // element 0 most significant

    function automatic void push_text(input logic [7:0] b);
        out_beat_t beat;
        beat.text = b;
        beat.last = 1'b0;
        expected_text.push_back(beat);
    endfunction

    function automatic void clear_line_count();
        for (int i = 0; i < NUMBER_DIGITS; i++)
            line_count[i] = '0;
    endfunction

    // Decimal increment that sticks at all nines
    function automatic void bump_line_count();
        logic saturated;
        logic carry;
        saturated = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++)
            if (line_count[i] != DIGIT_NINE)
                saturated = 1'b0;
        carry = !saturated;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            if (carry) begin
                if (line_count[i] == DIGIT_NINE) begin
                    line_count[i] = '0;
                end else begin
                    line_count[i] = line_count[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
    endfunction

    // Right-justified number, leading zeros as spaces, then a tab
    function automatic void push_line_number();
        logic leading;
        leading = 1'b1;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            if (leading && line_count[i] == 4'd0 && i != NUMBER_DIGITS - 1) begin
                push_text(CH_SPACE);
            end else begin
                leading = 1'b0;
                push_text(CH_ZERO + {4'd0, line_count[i]});
            end
        end
        push_text(CH_TAB);
    endfunction

    // Works out the output bytes that one input byte yields
    function automatic void filter_byte(input logic [7:0] ch, input logic new_file);
        logic [6:0] low7;
        int         size_before;
        out_beat_t  tail;
        size_before = expected_text.size();
        if (new_file) begin
            line_start = 1'b1;
            blank_kept = 1'b0;
            clear_line_count();
        end

        // line prefix and squeezing of empty lines
        if (line_start) begin
            if (reg_bits[REG_SQUEEZE_BLANK]) begin
                if (ch == CH_NL) begin
                    if (blank_kept)
                        return;
                    blank_kept = 1'b1;
                end else begin
                    blank_kept = 1'b0;
                end
            end
            if (reg_bits[REG_NUMBER_LINES]) begin
                if (!reg_bits[REG_NONBLANK_ONLY] || ch != CH_NL) begin
                    bump_line_count();
                    push_line_number();
                end else if (reg_bits[REG_SHOW_ENDS]) begin
                    for (int i = 0; i < NUMBER_DIGITS; i++)
                        push_text(CH_SPACE);
                    push_text(CH_TAB);
                end
            end
        end

        line_start = (ch == CH_NL);

        // body of the byte
        if (ch == CH_NL) begin
            if (reg_bits[REG_SHOW_ENDS])
                push_text(CH_DOLLAR);
            push_text(CH_NL);
        end else if (ch == CH_TAB) begin
            if (reg_bits[REG_SHOW_TABS]) begin
                push_text(CH_CARET);
                push_text(CH_UPPERI);
            end else begin
                push_text(CH_TAB);
            end
        end else if (reg_bits[REG_SHOW_NONPRINT]) begin
            if (ch[7]) begin
                push_text(CH_UPPERM);
                push_text(CH_DASH);
            end
            low7 = ch[6:0];
            if (low7 < CTRL_LIMIT || low7 == CH_DEL) begin
                push_text(CH_CARET);
                push_text(low7 == CH_DEL ? CH_QMARK : {1'b0, low7 | CTRL_SHOW});
            end else begin
                push_text({1'b0, low7});
            end
        end else begin
            push_text(ch);
        end

        // flag the final byte of this input
        if (expected_text.size() > size_before) begin
            tail = expected_text.pop_back();
            tail.last = 1'b1;
            expected_text.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_beat_t want;
        if (!rst_n) begin
            expected_text.delete();
            reg_bits   = '0;
            line_start = 1'b1;
            blank_kept = 1'b0;
            clear_line_count();
            failures   = 0;
            pending   <= 0;
        end else begin
            // register writes and read-back
            if (psel && penable && pready && paddr[4:2] < REG_COUNT) begin
                if (pwrite) begin
                    reg_bits[paddr[4:2]] = pwdata[0];
                end else if (prdata !== {31'd0, reg_bits[paddr[4:2]]}) begin
                    $error("prdata (register %0d): expected %h, got %h", paddr[4:2],
                           {31'd0, reg_bits[paddr[4:2]]}, prdata);
                    failures++;
                end
            end

            // input transfer
            if (in_valid && !in_stall)
                filter_byte(in_byte, file_start);

            // output transfer
            if (out_valid && !out_stall) begin
                if (expected_text.size() == 0) begin
                    $error("out_byte: expected nothing, got %h", out_byte);
                    failures++;
                end else begin
                    want = expected_text.pop_front();
                    if (out_byte !== want.text) begin
                        $error("out_byte: expected %h, got %h", want.text, out_byte);
                        failures++;
                    end
                    if (last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, last_of_run);
                        failures++;
                    end
                end
            end

            pending <= expected_text.size();
        end
    end

endmodule

FILE: tb/text_visualize_number_filter_tb.sv
// ----------------------------------------------------------------------------
// text_visualize_number_filter_tb
// Drives the text filter with directed byte sequences and then with random
// text over a range of register settings, including a long numbered run that
// carries the line counter into three digits. Input bursts and output stalls
// are random; a separate checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module text_visualize_number_filter_tb;
    import tvnf_pkg::*;

    localparam int     NUMBER_DIGITS = 6;
    localparam int     REG_COUNT     = 6;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 25;
    localparam int     COUNT_LINES   = 130;
    localparam longint RUN_LIMIT     = 20_000_000;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        file_start;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last_of_run;

    int          failures;
    int          pending;
    int          burst_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;
    int          mode_left   = 0;
    int          stall_phase = 0;

    text_visualize_number_filter #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
        .file_start(file_start),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .last_of_run(last_of_run)
    );

    tvnf_stream_checker #(
        .NUMBER_DIGITS(NUMBER_DIGITS)
    ) stream_check (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
        .file_start(file_start),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .last_of_run(last_of_run),
        .failures(failures), .pending(pending)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output stalls: a pattern that changes mode every so often
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % 7;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
            STALL_SPARSE: out_stall <= ($urandom_range(0, 4) == 0);
            default:      out_stall <= (stall_phase < 3);
        endcase
    end

    // One register access: setup phase, access phase until pready, then psel low
    task automatic apb_access(input logic write, input logic [4:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes every register (random upper bits), pokes unused addresses, reads back
    task automatic write_settings(input logic [5:0] bits);
        logic [31:0] data;
        for (int i = 0; i < REG_COUNT; i++)
        begin
            data    = $urandom;
            data[0] = bits[i];
            apb_access(1'b1, 5'(4 * i), data);
        end
        apb_access(1'b1, 5'(4 * REG_COUNT), $urandom);
        apb_access(1'b1, 5'(4 * (REG_COUNT + 1)), $urandom);
        for (int i = 0; i < REG_COUNT; i++)
            apb_access(1'b0, 5'(4 * i), 32'd0);
    endtask

    // Hold off input until every expected byte is out and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // One input transfer, with bursts and random gaps between them
    task automatic send(input logic [7:0] value, input logic new_file);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 16);
        end
        in_valid   <= 1'b1;
        in_byte    <= value;
        file_start <= new_file;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
    endtask

    // Text-like bytes: mostly printable and newlines, some control and high bytes
    function automatic logic [7:0] text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return CH_NL;
        else if (pick < 33)
            return CH_TAB;
        else if (pick < 70)
            return 8'($urandom_range(32, 126));
        else if (pick < 78)
            return 8'($urandom_range(0, 31));
        else if (pick < 82)
            return {1'b0, CH_DEL};
        else if (pick < 90)
            return 8'($urandom_range(128, 255));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [5:0] settings;
        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        in_byte    = '0;
        file_start = 1'b0;
        out_stall  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: bytes pass through untouched
        send(8'h00, 1'b0); send(8'hFF, 1'b0); send(CH_NL, 1'b0); send(CH_TAB, 1'b0);

        // Everything on: numbering, squeezing, visible tabs, ends and control bytes
        settle();
        write_settings(6'h3F);
        send(8'h41, 1'b1); send(CH_TAB, 1'b0); send(8'h00, 1'b0); send(8'h1F, 1'b0);
        send(8'h7F, 1'b0); send(8'h80, 1'b0); send(8'h89, 1'b0); send(8'h8A, 1'b0);
        send(8'hFF, 1'b0); send(CH_NL, 1'b0); send(CH_NL, 1'b0); send(CH_NL, 1'b0);
        send(CH_NL, 1'b0); send(8'h7E, 1'b0); send(CH_NL, 1'b0);

        // Nonblank-only numbering with ends shown: blank lines get padding
        settle();
        write_settings(6'h0E);
        send(CH_NL, 1'b1); send(CH_NL, 1'b0); send(8'h20, 1'b0); send(CH_NL, 1'b0);

        // Nonblank-only without numbering; a tab stays raw under nonprint display
        settle();
        write_settings(6'h24);
        send(CH_NL, 1'b0); send(CH_TAB, 1'b0); send(8'h01, 1'b0);

        // Random text over several settings, extremes first
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                settings = 6'h00;
            else if (p == 1)
                settings = 6'h3F;
            else
                settings = 6'($urandom_range(0, 63));
            settle();
            write_settings(settings);
            repeat (PHASE_ITEMS)
                send(text_byte(), $urandom_range(0, 24) == 0);
        end

        // Long numbered run: counter carries past 99 into three digits
        settle();
        write_settings(6'h0A);
        send(CH_NL, 1'b1);
        repeat (COUNT_LINES)
            send(($urandom_range(0, 7) == 0) ? 8'h61 : CH_NL, 1'b0);

        // Drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/tvnf_pkg.sv
design/tvnf_front.sv
design/tvnf_queue.sv
design/tvnf_back.sv
design/text_visualize_number_filter.sv
tb/tvnf_stream_checker.sv
tb/text_visualize_number_filter_tb.sv
